@@ design/wf3_pkg.sv @@
// Shared types, widths and codes of the 3x3 window filter.
// No dependencies; every other design file imports this package.
package wf3_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int KSIZE      = 3;
    localparam int DIM_W      = 13;
    localparam int ROW_W      = 12;
    localparam int COLO_W     = 10;
    localparam int OUT_W      = 28;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;
    localparam int PART_W     = PROD_W + 1;
    localparam int LB_W       = 2 * PIX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int MODE_W     = 2;
    localparam int WIDTH_W    = 11;
    localparam int DIV_W      = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_T  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_M  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 3'd6;

    localparam logic [MODE_W-1:0] MODE_CORR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DERIV = 2'd2;

    localparam logic [WIDTH_W-1:0]    WIDTH_RESET   = 11'd1024;
    localparam logic [DIM_W-1:0]      HEIGHT_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0]      HEIGHT_MAX    = 13'd4096;
    localparam logic [DIM_W-1:0]      SIZE_MIN      = 13'd3;
    localparam logic [DIV_W-1:0]      DIVISOR_RESET = 8'd1;
    localparam logic [CFG_DATA_W-1:0] COEF_ZERO     = 48'd0;
    localparam logic [CFG_DATA_W-1:0] COEF_MID_RESET = 48'd134217728;
    // (row - 1) mod height for row 0 at the reset height
    localparam logic [ROW_W-1:0]      RM1_RESET     = 12'd1023;

    typedef struct packed {
        logic             frame_start;
        logic [PIX_W-1:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    window_valid;
        logic [ROW_W-1:0]        centre_row;
        logic [COLO_W-1:0]       centre_col;
        logic                    frame_end;
    } result_t;

    typedef logic [KSIZE-1:0][PIX_W-1:0]  col_t;
    typedef logic [KSIZE-1:0][COEF_W-1:0] coef_col_t;
    typedef logic [PART_W-1:0]            part_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [OUT_W-1:0] sext_part(part_t p);
        return {{(OUT_W - PART_W){p[PART_W-1]}}, p};
    endfunction

endpackage

@@ design/wf3_cell.sv @@
// One window column cell: holds three pixels of a column, passes them on to
// its older neighbor and registers the column's kernel dot product. Uses wf3_pkg.
module wf3_cell
    import wf3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  col_t      col_in,
    input  coef_col_t coef,
    output col_t      col_out,
    output part_t     partial
);

    col_t  col_reg;
    part_t part_reg;
    part_t acc;
    logic signed [PROD_W-1:0] prod [KSIZE];

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < KSIZE; i++)
        begin
            prod[i] = $signed({1'b0, col_in[i]}) * $signed(coef[i]);
            acc     = acc + {{(PART_W - PROD_W){prod[i][PROD_W-1]}}, prod[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (en)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_reg <= acc;
        end
    end

    assign col_out = col_reg;
    assign partial = part_reg;

endmodule

@@ design/wf3_line_buf.sv @@
// Two line stores side by side in one memory word {upper, lower}, one write
// and one registered read per cycle. Uses wf3_pkg.
module wf3_line_buf
    import wf3_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [LB_W-1:0]          rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [LB_W-1:0]          wr_data
);

    logic [LB_W-1:0] mem [DEPTH];
    logic [LB_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old word on an address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/wf3_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Uses wf3_pkg for the status struct.
module wf3_divider
    import wf3_pkg::*;
#(
    parameter int NUM_W = 28,
    parameter int DEN_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_status_t      status,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quot        = quo_reg;
    assign rem         = rem_reg;

endmodule

@@ design/window_filter_3x3.sv @@
// An accepted pixel passes stage 1, stage 2 and the output register to its result;
// derivative mode holds a window inside the image in stage 2 until the divider is done.
// Throughput: one pixel per cycle unless stalled, set by the line-store port and the
// column cells; a derivative window inside the image waits on the bit-serial divider.
// A write to the height register stalls input while the row remainder is rebuilt.
// Reset: config to defaults, counters and window cleared; line stores are not cleared.
module window_filter_3x3
    import wf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_item_t             pix,
    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);

    // configuration
    logic [MODE_W-1:0]     mode_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [DIV_W-1:0]      divisor_reg;
    logic [CFG_DATA_W-1:0] coef_reg [KSIZE];

    // position state
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] rm1_reg, rm1_next;    // (row - 1) mod height

    // stage 1
    logic             s1_live_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [CW-1:0]    s1_idx_reg;
    logic             s1_ok_reg;
    logic [ROW_W-1:0] s1_cr_reg;
    logic [COLO_W-1:0] s1_cc_reg;
    logic             s1_last_reg;
    logic             fwd_hit_reg;
    logic [LB_W-1:0]  fwd_data_reg;

    // stage 2
    logic             s2_live_reg;
    logic             s2_ok_reg;
    logic [ROW_W-1:0] s2_cr_reg;
    logic [COLO_W-1:0] s2_cc_reg;
    logic             s2_last_reg;
    logic             div_ready_reg;

    // output
    logic             res_valid_reg;
    result_t          res_reg;

    // row remainder rebuild
    logic             mod_start_reg;
    logic             mod_busy;
    div_status_t      mod_status;
    logic [DIM_W-1:0] mod_rem;

    logic [DIM_W-1:0] w_raw, w_eff, h_eff, h_m1;
    logic [CW-1:0]    c0;
    logic [ROW_W-1:0] r0, rm1_eff, cr0;
    logic [DIM_W-1:0] c0d, r0d, cc_full;
    logic             c_wrap, r_wrap, win_ok, last0;
    logic             adv, s2_go, out_free, need_div, div_start;

    logic [LB_W-1:0]  rd_data, eff_data;
    col_t             new_col;
    col_t             col_link [KSIZE];
    coef_col_t        cell_coef [KSIZE];
    part_t            part [KSIZE];
    logic [OUT_W-1:0] s2_sum, div_num, div_quot, filt;
    logic [DIV_W-1:0] div_den;
    div_status_t      div_status;

    // -------- configuration writes --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CORR;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            divisor_reg <= DIVISOR_RESET;
            coef_reg[0] <= COEF_ZERO;
            coef_reg[1] <= COEF_MID_RESET;
            coef_reg[2] <= COEF_ZERO;
            mod_start_reg <= 1'b0;
        end
        else
        begin
            mod_start_reg <= cfg_write && (cfg_index == REG_HEIGHT);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                    REG_WIDTH:   width_reg   <= cfg_data[WIDTH_W-1:0];
                    REG_HEIGHT:  height_reg  <= cfg_data[DIM_W-1:0];
                    REG_DIVISOR: divisor_reg <= cfg_data[DIV_W-1:0];
                    REG_COEF_T:  coef_reg[0] <= cfg_data;
                    REG_COEF_M:  coef_reg[1] <= cfg_data;
                    REG_COEF_B:  coef_reg[2] <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // -------- position counters and centre position --------
    always_comb
    begin
        w_raw = {{(DIM_W - WIDTH_W){1'b0}}, width_reg};
        if (w_raw < SIZE_MIN)
            w_eff = SIZE_MIN;
        else if (w_raw > MAX_W_DIM)
            w_eff = MAX_W_DIM;
        else
            w_eff = w_raw;

        if (height_reg < SIZE_MIN)
            h_eff = SIZE_MIN;
        else if (height_reg > HEIGHT_MAX)
            h_eff = HEIGHT_MAX;
        else
            h_eff = height_reg;
        h_m1 = h_eff - 1'b1;

        c0      = pix.frame_start ? '0 : col_reg;
        r0      = pix.frame_start ? '0 : row_reg;
        rm1_eff = pix.frame_start ? h_m1[ROW_W-1:0] : rm1_reg;
        c0d     = {{(DIM_W - CW){1'b0}}, c0};
        r0d     = {1'b0, r0};

        c_wrap = (c0d + 1'b1) >= w_eff;
        r_wrap = (r0d + 1'b1) >= h_eff;
        win_ok = (r0 >= ROW_W'(2)) && (c0d >= DIM_W'(2)) && (r0d < h_eff) && (c0d < w_eff);
        last0  = c_wrap && r_wrap;

        // first column of a row: centre is the last column of the row before
        if (c0 == '0)
        begin
            cc_full = w_eff - 1'b1;
            cr0     = (rm1_eff == '0) ? h_m1[ROW_W-1:0] : rm1_eff - 1'b1;
        end
        else
        begin
            cc_full = c0d - 1'b1;
            cr0     = rm1_eff;
        end

        if (c_wrap)
        begin
            col_next = '0;
            row_next = r_wrap ? '0 : r0 + 1'b1;
            rm1_next = r_wrap ? h_m1[ROW_W-1:0] : r0;
        end
        else
        begin
            col_next = c0 + 1'b1;
            row_next = r0;
            rm1_next = rm1_eff;
        end
    end

    // -------- pipeline control --------
    assign out_free  = !res_valid_reg || !res_stall;
    assign need_div  = s2_ok_reg && (mode_reg == MODE_DERIV);
    assign s2_go     = s2_live_reg && out_free && (!need_div || div_ready_reg);
    assign mod_busy  = mod_start_reg || mod_status.busy || mod_status.done;
    assign adv       = (!s2_live_reg || s2_go) && !mod_busy;
    assign pix_stall = !adv;
    assign div_start = s2_live_reg && need_div && !div_status.busy && !div_status.done
                       && !div_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            rm1_reg       <= RM1_RESET;
            s1_live_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            s2_live_reg   <= 1'b0;
            div_ready_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (mod_status.done)
            begin
                rm1_reg <= (mod_rem == '0) ? h_m1[ROW_W-1:0] : mod_rem[ROW_W-1:0] - 1'b1;
            end
            else if (adv && pix_valid)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                rm1_reg <= rm1_next;
            end

            if (adv)
            begin
                s1_live_reg <= pix_valid;
                fwd_hit_reg <= s1_live_reg && (s1_idx_reg == c0);
                s2_live_reg <= s1_live_reg;
            end

            if (div_status.done)
                div_ready_reg <= 1'b1;
            else if (s2_go)
                div_ready_reg <= 1'b0;

            if (s2_go)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= pix.pixel;
            s1_idx_reg   <= c0;
            s1_ok_reg    <= win_ok;
            s1_cr_reg    <= cr0;
            s1_cc_reg    <= cc_full[COLO_W-1:0];
            s1_last_reg  <= last0;
            fwd_data_reg <= {eff_data[PIX_W-1:0], s1_px_reg};
            s2_ok_reg    <= s1_ok_reg;
            s2_cr_reg    <= s1_cr_reg;
            s2_cc_reg    <= s1_cc_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (s2_go)
        begin
            res_reg.filtered     <= filt;
            res_reg.window_valid <= s2_ok_reg;
            res_reg.centre_row   <= s2_cr_reg;
            res_reg.centre_col   <= s2_cc_reg;
            res_reg.frame_end    <= s2_last_reg;
        end
    end

    // -------- line stores --------
    wf3_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (c0),
        .rd_data (rd_data),
        .wr_en   (adv && s1_live_reg),
        .wr_addr (s1_idx_reg),
        .wr_data ({eff_data[PIX_W-1:0], s1_px_reg})
    );

    // back-to-back requests at one column: take what the previous one wrote
    assign eff_data = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign new_col  = {s1_px_reg, eff_data[PIX_W-1:0], eff_data[LB_W-1:PIX_W]};

    // -------- window column cells, newest column at the highest index --------
    for (genvar j = 0; j < KSIZE; j++)
    begin : g_cell
        for (genvar i = 0; i < KSIZE; i++)
        begin : g_coef
            assign cell_coef[j][i] = (mode_reg == MODE_CONV)
                ? coef_reg[KSIZE-1-i][(KSIZE-1-j)*COEF_W +: COEF_W]
                : coef_reg[i][j*COEF_W +: COEF_W];
        end

        wf3_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv && s1_live_reg),
            .col_in  ((j == KSIZE - 1) ? new_col : col_link[(j + 1) % KSIZE]),
            .coef    (cell_coef[j]),
            .col_out (col_link[j]),
            .partial (part[j])
        );
    end

    assign s2_sum = sext_part(part[0]) + sext_part(part[1]) + sext_part(part[2]);

    // -------- derivative division --------
    assign div_num = s2_sum[OUT_W-1] ? -s2_sum : s2_sum;
    assign div_den = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;

    wf3_divider #(
        .NUM_W (OUT_W),
        .DEN_W (DIV_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_status),
        .quot   (div_quot),
        .rem    ()
    );

    always_comb
    begin
        if (!s2_ok_reg)
            filt = '0;
        else if (need_div)
            filt = s2_sum[OUT_W-1] ? -div_quot : div_quot;
        else
            filt = s2_sum;
    end

    // -------- row remainder after a height change --------
    wf3_divider #(
        .NUM_W (ROW_W),
        .DEN_W (DIM_W)
    ) u_row_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start_reg),
        .num    (row_reg),
        .den    (h_eff),
        .status (mod_status),
        .quot   (),
        .rem    (mod_rem)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_mod_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> pix_stall)
        else $error("pixel accepted during row remainder rebuild");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) |=> s1_live_reg)
        else $error("accepted pixel missing from stage 1");

    a_quot_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_ready_reg |-> (s2_live_reg && need_div))
        else $error("held quotient without a dividing request in stage 2");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.window_valid) |-> (res.filtered == '0))
        else $error("border result not zero");

    a_go_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go |=> res_valid)
        else $error("result lost on the way to the output register");
`endif

endmodule

@@ tb/window_filter_3x3_tb.sv @@
// Testbench for window_filter_3x3: streams raster pixels in random bursts against a stalling
// receiver, predicts every centred window result and checks it field by field.
// Depends on wf3_pkg and the window_filter_3x3 RTL only.
module window_filter_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wf3_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam longint FILT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint FILT_MIN = -(longint'(1) <<< (OUT_W - 1));

    typedef enum int {STALL_NONE, STALL_SCATTER, STALL_LONG} stall_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    pix_item_t             pix = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    result_t               res;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    window_filter_3x3 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the filter: registers, line stores, window and raster position
    logic [MODE_W-1:0]     mode_q = MODE_CORR;
    logic [WIDTH_W-1:0]    width_q = WIDTH_RESET;
    logic [DIM_W-1:0]      height_q = HEIGHT_RESET;
    logic [DIV_W-1:0]      divisor_q = DIVISOR_RESET;
    logic [CFG_DATA_W-1:0] coef_q [KSIZE] = '{COEF_ZERO, COEF_MID_RESET, COEF_ZERO};
    logic [PIX_W-1:0]      upper_line [LINE_DEPTH] = '{default: '0};
    logic [PIX_W-1:0]      lower_line [LINE_DEPTH] = '{default: '0};
    logic [PIX_W-1:0]      win [KSIZE][KSIZE] = '{default: '0};
    int unsigned           row_pos = 0;
    int unsigned           col_pos = 0;

    pix_item_t    pixel_backlog [$];
    result_t      centre_results [$];
    bit           pix_fire = 1'b0;
    int unsigned  bad_results = 0;
    int unsigned  cycle_count = 0;
    int unsigned  send_gap = 0;
    int unsigned  send_burst = 1;
    int unsigned  stall_hold = 0;
    stall_style_t stall_style = STALL_NONE;

    function automatic int unsigned eff_width(logic [WIDTH_W-1:0] v);
        if (v < 3)
            return 3;
        if (v > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_height(logic [DIM_W-1:0] v);
        if (v < SIZE_MIN)
            return 32'(SIZE_MIN);
        if (v > HEIGHT_MAX)
            return 32'(HEIGHT_MAX);
        return 32'(v);
    endfunction

    // advances the shadow by one pixel and returns the result centred one row and column back
    function automatic result_t filter_window(pix_item_t item);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        int kr;
        int kc;
        logic signed [COEF_W-1:0] k;
        longint acc;
        longint d;
        logic inside_img;
        result_t o;
        w = eff_width(width_q);
        h = eff_height(height_q);
        if (item.frame_start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        idx = c % LINE_DEPTH;
        for (int i = 0; i < KSIZE; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[idx];
        win[1][2] = lower_line[idx];
        win[2][2] = item.pixel;
        upper_line[idx] = lower_line[idx];
        lower_line[idx] = item.pixel;

        inside_img = (r >= 2) && (c >= 2) && (r < h) && (c < w);
        acc = 0;
        if (inside_img)
        begin
            for (int i = 0; i < KSIZE; i++)
                for (int j = 0; j < KSIZE; j++)
                begin
                    // convolution walks the kernel rotated by half a turn
                    kr = (mode_q == MODE_CONV) ? KSIZE - 1 - i : i;
                    kc = (mode_q == MODE_CONV) ? KSIZE - 1 - j : j;
                    k = coef_q[kr][COEF_W*kc +: COEF_W];
                    acc += longint'(win[i][j]) * longint'(k);
                end
            if (mode_q == MODE_DERIV)
            begin
                d = (divisor_q == 0) ? 1 : longint'(divisor_q);
                acc = acc / d;
            end
            if (acc > FILT_MAX)
                acc = FILT_MAX;
            if (acc < FILT_MIN)
                acc = FILT_MIN;
        end

        o.filtered = acc[OUT_W-1:0];
        o.window_valid = inside_img;
        o.centre_col = COLO_W'((c == 0) ? w - 1 : c - 1);
        // before the centre exists it wraps into the previous frame
        o.centre_row = ROW_W'((r + 2 * h - 1 - ((c == 0) ? 1 : 0)) % h);
        o.frame_end = (c + 1 >= w) && (r + 1 >= h);

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFF);
        end
        else
        begin
            col_pos = c + 1;
        end
        return o;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef_row();
        logic [CFG_DATA_W-1:0] v;
        for (int i = 0; i < KSIZE; i++)
            case ($urandom_range(5))
                0: v[COEF_W*i +: COEF_W] = 16'h7FFF;
                1: v[COEF_W*i +: COEF_W] = 16'h8000;
                2: v[COEF_W*i +: COEF_W] = 16'h0000;
                3: v[COEF_W*i +: COEF_W] = 16'h0800;
                default: v[COEF_W*i +: COEF_W] = COEF_W'($urandom);
            endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MODE:    mode_q = val[MODE_W-1:0];
            REG_WIDTH:   width_q = val[WIDTH_W-1:0];
            REG_HEIGHT:  height_q = val[DIM_W-1:0];
            REG_DIVISOR: divisor_q = val[DIV_W-1:0];
            REG_COEF_T:  coef_q[0] = val;
            REG_COEF_M:  coef_q[1] = val;
            REG_COEF_B:  coef_q[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_pixel(input logic fs, input logic [PIX_W-1:0] px);
        pix_item_t item;
        item.frame_start = fs;
        item.pixel = px;
        pixel_backlog.push_back(item);
    endtask

    // random pixels; an occasional stray frame_start breaks the frame
    task automatic queue_run(input int unsigned n, input logic fs_first);
        for (int unsigned i = 0; i < n; i++)
            queue_pixel((i == 0 && fs_first) || ($urandom_range(63) == 0), PIX_W'($urandom));
    endtask

    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || centre_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_bad(input string what, input result_t want, input result_t got);
        bad_results++;
        if (bad_results <= SHOWN_MISMATCHES)
        begin
            $display("%s: expected filt=%0d valid=%0b row=%0d col=%0d end=%0b",
                     what, want.filtered, want.window_valid, want.centre_row,
                     want.centre_col, want.frame_end);
            $display("    got filt=%0d valid=%0b row=%0d col=%0d end=%0b",
                     got.filtered, got.window_valid, got.centre_row,
                     got.centre_col, got.frame_end);
        end
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pix_fire)
                void'(pixel_backlog.pop_front());
            if (!pix_valid || pix_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pix_valid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    pix_valid <= 1'b1;
                    pix <= pixel_backlog[0];
                    send_burst--;
                    if (send_burst == 0)
                    begin
                        send_gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(6, 1);
                        send_burst = ($urandom_range(3) == 0) ? $urandom_range(150, 40)
                                                              : $urandom_range(8, 1);
                    end
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern with a randomly drawn style: none, scattered or long holds
    always @(negedge clk)
    begin
        if (cycle_count % 256 == 0)
            stall_style = stall_style_t'($urandom_range(2));
        if (stall_hold > 0)
        begin
            stall_hold--;
            res_stall <= 1'b1;
        end
        else if (stall_style == STALL_SCATTER)
        begin
            res_stall <= ($urandom_range(3) == 0);
        end
        else if (stall_style == STALL_LONG && $urandom_range(15) == 0)
        begin
            stall_hold = $urandom_range(12, 1);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        pix_fire = rst_n && pix_valid && !pix_stall;
        if (pix_fire)
            centre_results.push_back(filter_window(pix));
        if (rst_n && res_valid && !res_stall)
        begin
            if (centre_results.size() == 0)
            begin
                note_bad("unexpected result", '0, res);
            end
            else
            begin
                want = centre_results.pop_front();
                if (res.filtered !== want.filtered || res.window_valid !== want.window_valid
                    || res.centre_row !== want.centre_row || res.centre_col !== want.centre_col
                    || res.frame_end !== want.frame_end)
                    note_bad("mismatch", want, res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned n;
        int unsigned area;
        int unsigned wv;
        int unsigned hv;
        bit fresh;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: centre-only kernel of weight 2048, 1024 wide; first centre wraps to the last column
        queue_pixel(1'b1, 8'd0);
        queue_pixel(1'b0, 8'd255);
        wait_idle();

        // sizes out of range clamp to 3 wide by 4096 rows; divisor zero acts as one
        write_reg(REG_WIDTH, 48'd0);
        write_reg(REG_HEIGHT, 48'h1FFF);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_CORR));
        write_reg(REG_DIVISOR, 48'd0);
        write_reg(REG_COEF_T, {3{16'h7FFF}});
        write_reg(REG_COEF_M, {16'h8000, 16'h0800, 16'h8000});
        write_reg(REG_COEF_B, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 9; i++)
            queue_pixel(i == 0, (i % 4 == 3) ? 8'd0 : 8'd255);
        wait_idle();
        // one valid window per 3-wide row from here on
        write_reg(REG_MODE, CFG_DATA_W'(MODE_CONV));
        queue_run(3, 1'b0);
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DERIV));
        queue_run(3, 1'b0);
        wait_idle();
        write_reg(REG_DIVISOR, 48'd255);
        queue_run(3, 1'b0);
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
        queue_run(3, 1'b0);
        wait_idle();
        // height drops below the current row: row stays invalid, then wraps to row 0
        write_reg(REG_HEIGHT, CFG_DATA_W'(SIZE_MIN));
        queue_run(3, 1'b0);
        wait_idle();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            fresh = ($urandom_range(5) != 0);
            case ($urandom_range(15))
                0: wv = LINE_DEPTH;
                1: wv = 2047;
                2: wv = $urandom_range(2);
                3: wv = $urandom_range(1023, 13);
                default: wv = $urandom_range(12, 3);
            endcase
            // widening mid-frame would read line-store entries no row has written yet
            if (fresh || eff_width(WIDTH_W'(wv)) <= eff_width(width_q))
                write_reg(REG_WIDTH, CFG_DATA_W'(wv));
            case ($urandom_range(15))
                0: hv = 4096;
                1: hv = 8191;
                2: hv = $urandom_range(2);
                3: hv = 1024;
                default: hv = $urandom_range(8, 3);
            endcase
            write_reg(REG_HEIGHT, CFG_DATA_W'(hv));
            write_reg(REG_MODE, CFG_DATA_W'($urandom_range(3)));
            if ($urandom_range(1))
                case ($urandom_range(7))
                    0: write_reg(REG_DIVISOR, 48'd0);
                    1: write_reg(REG_DIVISOR, 48'd1);
                    2: write_reg(REG_DIVISOR, 48'd255);
                    default: write_reg(REG_DIVISOR, CFG_DATA_W'($urandom_range(255)));
                endcase
            if ($urandom_range(1))
                write_reg(REG_COEF_T, pick_coef_row());
            if ($urandom_range(1))
                write_reg(REG_COEF_M, pick_coef_row());
            if ($urandom_range(1))
                write_reg(REG_COEF_B, pick_coef_row());

            area = eff_width(width_q) * eff_height(height_q);
            if (fresh && area <= 200)
                n = area + $urandom_range(2 * eff_width(width_q));
            else
                n = $urandom_range(60, 5);
            queue_run(n, fresh);
            random_sent += n;
            wait_idle();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ window_filter_3x3.f @@
design/wf3_pkg.sv
design/wf3_cell.sv
design/wf3_line_buf.sv
design/wf3_divider.sv
design/window_filter_3x3.sv
tb/window_filter_3x3_tb.sv
